// ----- sv/heap_sorter_core_assert.svh -----
// Assertion macros shared by the heap sorter RTL.
// Each macro expects clock aclk and active-low reset aresetn in scope.
`ifndef HEAP_SORTER_CORE_ASSERT_SVH
`define HEAP_SORTER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

`define HS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`define HS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define HS_ASSERT_IMP(label, ante, cons, msg)

`define HS_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ----- sv/hs_pkg.sv -----
package hs_pkg;

    localparam int DATA_W          = 32;
    localparam int MAX_ITEMS_DEF   = 64;

    typedef logic signed [DATA_W-1:0] data_t;

    // Sequencer states: load, sift-down steps, root swap, emission.
    typedef enum logic [3:0] {
        ST_LOAD,
        ST_SD_RDNODE,
        ST_SD_HELD,
        ST_SD_CHILD,
        ST_SD_LEFT,
        ST_SD_RIGHT,
        ST_SD_DEC,
        ST_SD_FIN,
        ST_NEXT,
        ST_SW_RD0,
        ST_SW_RDK,
        ST_SW_WR,
        ST_EM_RD,
        ST_EM_PUT
    } hs_state_t;

endpackage

// ----- sv/heap_sorter_core.sv -----
// Loading takes one beat per cycle; after the beat marked last the set of n elements is heap
// sorted by n/2 + n - 1 sift-downs in all, then emitted one beat at a time, each beat waiting
// while the receiver holds the previous one; no new input is taken until the last is emitted.
// Throughput is set by the single read port of the element store and the one shared compare unit.
// Reset (aresetn, synchronous, active low) clears the sequencer, the element count, the overflow
// flag and the output valid; the element store has no reset and needs no clearing pass.
module heap_sorter_core #(
    parameter int MAX_ITEMS = hs_pkg::MAX_ITEMS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [31:0]           s_tdata,   // [31:0] value (signed)
    input  logic                  s_tlast,   // last_item
    // Result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_tdata,   // [31:0] sorted_value (signed)
    output logic                  m_tlast,   // end_of_run
    output logic                  m_tuser    // [0] dropped
);
    import hs_pkg::*;

    // Index into the store, a count that can reach MAX_ITEMS, and a child index
    // wide enough to hold 2 * index + 2 without wrapping.
    localparam int IDX_W = $clog2(MAX_ITEMS);
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam int CH_W  = IDX_W + 2;

    hs_state_t          state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               ovf_reg, ovf_next;
    logic [CNT_W-1:0]   n_reg, n_next;
    logic [CNT_W-1:0]   k_reg, k_next;
    logic [CNT_W-1:0]   size_reg, size_next;
    logic [IDX_W-1:0]   node_reg, node_next;
    logic [IDX_W-1:0]   child_reg, child_next;
    logic               extract_reg, extract_next;
    data_t              held_reg, held_next;
    data_t              cval_reg, cval_next;
    data_t              tmp_reg, tmp_next;
    logic               m_valid_reg, m_valid_next;
    data_t              m_data_reg, m_data_next;
    logic               m_last_reg, m_last_next;
    logic               m_user_reg, m_user_next;

    // Store port and the shared comparator operands.
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    data_t              ram_wdata;
    logic [IDX_W-1:0]   ram_raddr;
    data_t              ram_rdata;
    data_t              cmp_a, cmp_b;
    logic               cmp_lt;

    // Helpers for the load and sift steps.
    logic               full;
    logic [CNT_W-1:0]   n_new;
    logic [CNT_W-1:0]   half_m1;
    logic [CH_W-1:0]    left_of_node;
    logic [CH_W-1:0]    left_of_child;
    logic [CH_W-1:0]    right_of_left;
    logic [CH_W-1:0]    size_ext;
    logic               s_fire;

    hs_ram #(
        .DEPTH  (MAX_ITEMS),
        .ADDR_W (IDX_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    hs_cmp u_cmp (
        .a  (cmp_a),
        .b  (cmp_b),
        .lt (cmp_lt)
    );

    assign s_tready = (state_reg == ST_LOAD);
    assign s_fire   = s_tvalid && s_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;

    assign full          = (count_reg == CNT_W'(MAX_ITEMS));
    assign n_new         = full ? count_reg : count_reg + CNT_W'(1);
    assign half_m1       = (n_new >> 1) - CNT_W'(1);
    assign left_of_node  = {1'b0, node_reg, 1'b1};
    assign left_of_child = {1'b0, child_reg, 1'b1};
    assign right_of_left = CH_W'(child_reg) + CH_W'(1);
    assign size_ext      = CH_W'(size_reg);

    // The comparator picks the larger child first, then tests the held value against it.
    always_comb begin
        if (state_reg == ST_SD_RIGHT) begin
            cmp_a = cval_reg;
            cmp_b = ram_rdata;
        end else begin
            cmp_a = held_reg;
            cmp_b = cval_reg;
        end
    end

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        ovf_next     = ovf_reg;
        n_next       = n_reg;
        k_next       = k_reg;
        size_next    = size_reg;
        node_next    = node_reg;
        child_next   = child_reg;
        extract_next = extract_reg;
        held_next    = held_reg;
        cval_next    = cval_reg;
        tmp_next     = tmp_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        m_user_next  = m_user_reg;
        ram_we       = 1'b0;
        ram_waddr    = node_reg;
        ram_wdata    = held_reg;
        ram_raddr    = node_reg;

        unique case (state_reg)
            ST_LOAD: begin
                if (s_fire) begin
                    if (!full) begin
                        ram_we     = 1'b1;
                        ram_waddr  = count_reg[IDX_W-1:0];
                        ram_wdata  = data_t'(s_tdata);
                        count_next = n_new;
                    end else begin
                        ovf_next = 1'b1;
                    end
                    if (s_tlast) begin
                        n_next       = n_new;
                        extract_next = 1'b0;
                        if (n_new < CNT_W'(2)) begin
                            k_next     = '0;
                            state_next = ST_EM_RD;
                        end else begin
                            k_next     = half_m1;
                            node_next  = half_m1[IDX_W-1:0];
                            size_next  = n_new;
                            state_next = ST_SD_RDNODE;
                        end
                    end
                end
            end
            ST_SD_RDNODE: begin
                ram_raddr  = node_reg;
                state_next = ST_SD_HELD;
            end
            ST_SD_HELD: begin
                held_next  = ram_rdata;
                state_next = ST_SD_CHILD;
            end
            ST_SD_CHILD: begin
                if (left_of_node >= size_ext) begin
                    ram_we     = 1'b1;
                    ram_waddr  = node_reg;
                    ram_wdata  = held_reg;
                    state_next = ST_NEXT;
                end else begin
                    child_next = left_of_node[IDX_W-1:0];
                    ram_raddr  = left_of_node[IDX_W-1:0];
                    state_next = ST_SD_LEFT;
                end
            end
            ST_SD_LEFT: begin
                cval_next = ram_rdata;
                if (right_of_left < size_ext) begin
                    ram_raddr  = right_of_left[IDX_W-1:0];
                    state_next = ST_SD_RIGHT;
                end else begin
                    state_next = ST_SD_DEC;
                end
            end
            ST_SD_RIGHT: begin
                if (cmp_lt) begin
                    cval_next  = ram_rdata;
                    child_next = right_of_left[IDX_W-1:0];
                end
                state_next = ST_SD_DEC;
            end
            ST_SD_DEC: begin
                ram_we    = 1'b1;
                ram_waddr = node_reg;
                if (cmp_lt) begin
                    // Larger child moves up; continue one level down.
                    ram_wdata = cval_reg;
                    node_next = child_reg;
                    if (left_of_child < size_ext) begin
                        child_next = left_of_child[IDX_W-1:0];
                        ram_raddr  = left_of_child[IDX_W-1:0];
                        state_next = ST_SD_LEFT;
                    end else begin
                        state_next = ST_SD_FIN;
                    end
                end else begin
                    ram_wdata  = held_reg;
                    state_next = ST_NEXT;
                end
            end
            ST_SD_FIN: begin
                ram_we     = 1'b1;
                ram_waddr  = node_reg;
                ram_wdata  = held_reg;
                state_next = ST_NEXT;
            end
            ST_NEXT: begin
                if (!extract_reg) begin
                    if (k_reg == '0) begin
                        extract_next = 1'b1;
                        k_next       = n_reg - CNT_W'(1);
                        state_next   = ST_SW_RD0;
                    end else begin
                        k_next     = k_reg - CNT_W'(1);
                        node_next  = IDX_W'(k_reg - CNT_W'(1));
                        size_next  = n_reg;
                        state_next = ST_SD_RDNODE;
                    end
                end else begin
                    if (k_reg == CNT_W'(1)) begin
                        k_next     = '0;
                        state_next = ST_EM_RD;
                    end else begin
                        k_next     = k_reg - CNT_W'(1);
                        state_next = ST_SW_RD0;
                    end
                end
            end
            ST_SW_RD0: begin
                ram_raddr  = '0;
                state_next = ST_SW_RDK;
            end
            ST_SW_RDK: begin
                tmp_next   = ram_rdata;
                ram_raddr  = k_reg[IDX_W-1:0];
                state_next = ST_SW_WR;
            end
            ST_SW_WR: begin
                // Old root goes to the end of the heap; the old end becomes the value to sift.
                ram_we     = 1'b1;
                ram_waddr  = k_reg[IDX_W-1:0];
                ram_wdata  = tmp_reg;
                held_next  = ram_rdata;
                node_next  = '0;
                size_next  = k_reg;
                state_next = ST_SD_CHILD;
            end
            ST_EM_RD: begin
                ram_raddr = k_reg[IDX_W-1:0];
                if (!m_valid_reg || m_tready) begin
                    state_next = ST_EM_PUT;
                end
            end
            ST_EM_PUT: begin
                m_valid_next = 1'b1;
                m_data_next  = ram_rdata;
                m_last_next  = (k_reg == n_reg - CNT_W'(1));
                m_user_next  = ovf_reg;
                if (k_reg == n_reg - CNT_W'(1)) begin
                    count_next = '0;
                    ovf_next   = 1'b0;
                    state_next = ST_LOAD;
                end else begin
                    k_next     = k_reg + CNT_W'(1);
                    state_next = ST_EM_RD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg       <= n_next;
        k_reg       <= k_next;
        size_reg    <= size_next;
        node_reg    <= node_next;
        child_reg   <= child_next;
        extract_reg <= extract_next;
        held_reg    <= held_next;
        cval_reg    <= cval_next;
        tmp_reg     <= tmp_next;
        m_data_reg  <= m_data_next;
        m_last_reg  <= m_last_next;
        m_user_reg  <= m_user_next;
    end

`include "heap_sorter_core_assert.svh"

    `HS_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CNT_W'(MAX_ITEMS), "element count overran")
    `HS_ASSERT_IMP(a_emit_no_overwrite, state_reg == ST_EM_PUT, !m_valid_reg, "result overwritten")
    `HS_ASSERT_IMP(a_swap_index, state_reg == ST_SW_RD0, k_reg != '0, "swap with the root itself")
    `HS_ASSERT_NEXT(a_load_only_idle, s_fire && !s_tlast, state_reg == ST_LOAD, "left load early")

endmodule

// ----- sv/hs_ram.sv -----
module hs_ram #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  logic                aclk,
    input  logic                we,
    input  logic [ADDR_W-1:0]   waddr,
    input  hs_pkg::data_t       wdata,
    input  logic [ADDR_W-1:0]   raddr,
    output hs_pkg::data_t       rdata
);
    import hs_pkg::*;

    data_t mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- sv/hs_cmp.sv -----
module hs_cmp (
    input  hs_pkg::data_t a,
    input  hs_pkg::data_t b,
    output logic          lt
);
    import hs_pkg::*;

    // Signed ordering of two elements.
    assign lt = (a < b);

endmodule

// ----- bench/heap_sorter_checker.sv -----
module heap_sorter_checker #(
    parameter int MAX_ITEMS = hs_pkg::MAX_ITEMS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value (signed)
    input  logic        s_tlast,   // last_item
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,   // [31:0] sorted_value (signed)
    input  logic        m_tlast,   // end_of_run
    input  logic        m_tuser,   // [0] dropped
    output int          mismatches,
    output int          results_due
);
    import hs_pkg::*;

    typedef struct packed {
        data_t sorted_value;
        logic  end_of_run;
        logic  dropped;
    } sorted_beat_t;

    // Elements of the set being loaded, and whether any were thrown away.
    data_t        set_values[$];
    logic         set_spilled;
    sorted_beat_t ascending_due[$];

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("%0t: mismatch on %s, expected %0h, got %0h", $time, what, want, got);
        mismatches++;
    endtask

    // Signed ascending order; equal elements simply sit side by side.
    function automatic void sort_set_ascending();
        data_t key;
        int    j;
        for (int i = 1; i < set_values.size(); i++) begin
            key = set_values[i];
            j = i - 1;
            while (j >= 0 && set_values[j] > key) begin
                set_values[j + 1] = set_values[j];
                j--;
            end
            set_values[j + 1] = key;
        end
    endfunction

    always @(posedge aclk) begin
        sorted_beat_t want;
        if (!aresetn) begin
            set_values.delete();
            ascending_due.delete();
            set_spilled = 1'b0;
            mismatches  = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (ascending_due.size() == 0) begin
                    report_mismatch("unexpected result beat", '0, m_tdata);
                end else begin
                    want = ascending_due.pop_front();
                    if (m_tdata !== want.sorted_value)
                        report_mismatch("sorted_value", want.sorted_value, m_tdata);
                    if (m_tlast !== want.end_of_run)
                        report_mismatch("end_of_run", 32'(want.end_of_run), 32'(m_tlast));
                    if (m_tuser !== want.dropped)
                        report_mismatch("dropped", 32'(want.dropped), 32'(m_tuser));
                end
            end
            if (s_tvalid && s_tready) begin
                if (set_values.size() < MAX_ITEMS)
                    set_values.push_back(data_t'(s_tdata));
                else
                    set_spilled = 1'b1;
                if (s_tlast) begin
                    sort_set_ascending();
                    for (int k = 0; k < set_values.size(); k++) begin
                        want.sorted_value = set_values[k];
                        want.end_of_run   = (k == set_values.size() - 1);
                        want.dropped      = set_spilled;
                        ascending_due.push_back(want);
                    end
                    set_values.delete();
                    set_spilled = 1'b0;
                end
            end
        end
        results_due = ascending_due.size();
    end

endmodule

// ----- bench/testbench.sv -----
module testbench;
    import hs_pkg::*;

    // Generous stop: the receiver may stall for long stretches, so this limit is
    // many times the slowest run.
    localparam int CYCLE_LIMIT  = 1_500_000;
    localparam int RANDOM_ITEMS = 240;
    localparam int HOLD_CYCLES  = 600;
    localparam int HOLD_AFTER   = 30;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;     // [31:0] value (signed)
    logic        s_tlast;     // last_item
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;     // [31:0] sorted_value (signed)
    logic        m_tlast;     // end_of_run
    logic        m_tuser;     // [0] dropped

    int mismatches;
    int results_due;
    int cycle_count  = 0;
    int random_items = 0;

    // Idle percentages of each side; the stimulus process moves them through the phases.
    int tx_idle_pct = 19;
    int rx_idle_pct = 64;

    // Receiver state: beats taken so far and the remaining cycles of the long hold.
    int  rx_beats  = 0;
    int  hold_left = 0;
    logic hold_done = 1'b0;

    always #4 aclk = ~aclk;

    heap_sorter_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    heap_sorter_checker checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser),
        .mismatches  (mismatches),
        .results_due (results_due)
    );

    // Watchdog. Should the block hang, the run is stopped here with a failure.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL heap_sorter_core");
            $finish;
        end
    end

    // Receiver. It stalls at random according to the current phase, and once,
    // after a few dozen result beats, it holds off for a long stretch whilst the
    // sender keeps offering beats, so the block has to stall its input as well.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready)
                rx_beats <= rx_beats + 1;
            if (hold_left > 0) begin
                m_tready  <= 1'b0;
                hold_left <= hold_left - 1;
            end else if (!hold_done && rx_beats >= HOLD_AFTER) begin
                m_tready  <= 1'b0;
                hold_left <= HOLD_CYCLES;
                hold_done <= 1'b1;
            end else if (rx_idle_pct == 0) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Offers one beat and waits for the block to take it. A gap, when drawn,
    // drops tvalid in an earlier step than the one raising it again.
    task automatic offer_beat(input data_t elem, input logic last_one);
        if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= elem;
        s_tlast  <= last_one;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Mostly full-range values, with the extremes and a narrow band that makes
    // duplicates likely.
    function automatic data_t random_element();
        case ($urandom_range(9))
            0:       return data_t'(32'h8000_0000);
            1:       return data_t'(32'h7FFF_FFFF);
            2, 3:    return data_t'($urandom_range(7)) - data_t'(4);
            default: return data_t'($urandom);
        endcase
    endfunction

    // Sends a whole set of random elements, the final one marked last. The idle
    // phase follows the number of random beats sent so far.
    task automatic send_random_set(input int count);
        for (int i = 0; i < count; i++) begin
            if (random_items < RANDOM_ITEMS / 3) begin
                tx_idle_pct = 19;
                rx_idle_pct = 64;
            end else if (random_items < 2 * RANDOM_ITEMS / 3) begin
                tx_idle_pct = 64;
                rx_idle_pct = 19;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            offer_beat(random_element(), i == count - 1);
            random_items++;
        end
    endtask

    task automatic send_list(input data_t elems[$]);
        for (int i = 0; i < elems.size(); i++)
            offer_beat(elems[i], i == elems.size() - 1);
    endtask

    initial begin
        data_t single[$];
        data_t pair[$];
        data_t mixed[$];
        data_t falling[$];
        data_t rising[$];
        int    set_size;

        single  = '{data_t'(32'h8000_0000)};
        pair    = '{data_t'(32'h7FFF_FFFF), data_t'(32'h8000_0000)};
        mixed   = '{data_t'(0), data_t'(-1), data_t'(32'h7FFF_FFFF), data_t'(32'h8000_0000),
                    data_t'(-1), data_t'(0), data_t'(1), data_t'(32'h7FFF_FFFF)};
        falling = '{data_t'(500), data_t'(40), data_t'(3), data_t'(-20), data_t'(-600)};
        rising  = '{data_t'(-7), data_t'(-6), data_t'(100), data_t'(32'h7FFF_FFFE)};

        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed sets: a lone element, the two extremes, duplicates mixed with
        // the extremes, and sets already in descending and ascending order.
        send_list(single);
        send_list(pair);
        send_list(mixed);
        send_list(falling);
        send_list(rising);

        // A set one beyond capacity: the beat carrying the last mark is itself
        // dropped, yet it still closes the set and every result is flagged.
        send_random_set(MAX_ITEMS_DEF + 1);

        // Then random sets, mostly short, with the occasional one near or past capacity.
        while (random_items < RANDOM_ITEMS) begin
            if ($urandom_range(11) == 0)
                set_size = $urandom_range(MAX_ITEMS_DEF - 4, MAX_ITEMS_DEF + 6);
            else
                set_size = $urandom_range(1, 12);
            send_random_set(set_size);
        end
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;

        // Let the checker take in the final beat, drain the outstanding results,
        // then allow a few more cycles for any stray beat to show up.
        @(posedge aclk);
        while (results_due != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);

        if (mismatches == 0 && results_due == 0) begin
            $display("PASS heap_sorter_core");
        end else begin
            $display("FAIL heap_sorter_core");
        end
        $finish;
    end

endmodule
